/* hdl/isfd_pkg.sv */
// shared types, constants and scaling tables for the imu serial frame decoder
`default_nettype none

package isfd_pkg;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam int         BodyLen   = 10;
  localparam logic [3:0] ChkPos    = 4'(BodyLen);
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeRate  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  localparam int NumWords = 4;
  localparam int MagW     = 31;
  localparam int ScaledW  = 28;
  localparam int OutW     = 184;

  localparam logic signed [31:0] TempOfs = 32'sd239403008;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DEN_1   = 2'd0,
    DEN_5   = 2'd1,
    DEN_25  = 2'd2,
    DEN_100 = 2'd3
  } den_e;

  typedef struct packed {
    kind_e                     kind;
    logic [7:0]                type_byte;
    logic [NumWords-1:0][15:0] words;
  } frame_t;

  typedef struct packed {
    logic [14:0] mult;
    logic        add_ofs;
    logic        zext;
    den_e        den;
  } lane_cfg_t;

  function automatic kind_e kind_of(input logic [7:0] t);
    kind_e k;
    case (t)
      TypeAccel: k = KIND_ACCEL;
      TypeRate:  k = KIND_RATE;
      TypeAngle: k = KIND_ANGLE;
      default:   k = KIND_OTHER;
    endcase
    return k;
  endfunction

  // scale factor, offset and divisor for one lane of one frame kind
  function automatic lane_cfg_t lane_cfg(input kind_e k, input logic aux);
    lane_cfg_t c;
    c = '{mult: 15'd0, add_ofs: 1'b0, zext: 1'b0, den: DEN_1};
    case (k)
      KIND_ACCEL: begin
        if (aux) begin
          c.mult    = 15'd19276;
          c.add_ofs = 1'b1;
          c.den     = DEN_100;
        end else begin
          c.mult = 15'd1568;
          c.den  = DEN_5;
        end
      end
      KIND_RATE: begin
        if (aux) begin
          c.mult = 15'd16384;
          c.den  = DEN_25;
        end else begin
          c.mult = 15'd4000;
        end
      end
      KIND_ANGLE: begin
        if (aux) begin
          c.mult = 15'd1;
          c.zext = 1'b1;
        end else begin
          c.mult = 15'd360;
        end
      end
      default: c.mult = 15'd0;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] den_value(input den_e d);
    logic [6:0] v;
    case (d)
      DEN_5:   v = 7'd5;
      DEN_25:  v = 7'd25;
      DEN_100: v = 7'd100;
      default: v = 7'd1;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] den_half(input den_e d);
    logic [5:0] v;
    case (d)
      DEN_5:   v = 6'd2;
      DEN_25:  v = 6'd12;
      DEN_100: v = 6'd50;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

  // floor(2^32 / divisor), estimate is low by at most one
  function automatic logic [31:0] den_recip(input den_e d);
    logic [31:0] v;
    case (d)
      DEN_5:   v = 32'd858993459;
      DEN_25:  v = 32'd171798691;
      DEN_100: v = 32'd42949672;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/imu_serial_frame_decoder.sv */
// top level of the imu serial frame decoder
// usage:
//   s_axis carries one received serial byte per item in tdata; tready is low
//   only while the frame queue is full, which happens once m_axis has stalled
//   long enough for two more good frames to arrive
//   the collector hunts for header 0x55, gathers the 11-byte frame and checks
//   the 8-bit sum; a bad frame is dropped, a good one enters a two-entry queue
//   m_axis gives one item per good frame: kind in tuser, type byte, four raw
//   words and four Q16 scaled values in tdata (angle frames give an integer
//   version in aux)
//   path: a good frame is written into the frame queue, then passes through the
//   scaling pipeline registers (multiply, offset and magnitude, reciprocal
//   multiply, correction, sign and output register)
//   throughput: one byte per cycle in while the queue has room; the pipeline
//   takes one frame per cycle when m_axis is ready
//   a stall on m_axis freezes the pipeline; bytes are still taken while the
//   queue has room
//   reset clears the collector, queue and pipeline valids; no frame pending
`default_nettype none

module imu_serial_frame_decoder
  import isfd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire logic [7:0]      s_axis_tdata_i,   // rx_byte
  output logic                 m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i,
  // type_byte, raw_word_0..3, scaled_x, scaled_y, scaled_z, scaled_aux
  output logic [OutW-1:0]      m_axis_tdata_o,
  output logic [1:0]           m_axis_tuser_o    // frame_kind
);

  frame_t front_frame, q_frame;
  logic   front_push, q_full, q_empty, q_pop;
  logic   byte_acc;

  assign s_axis_tready_o = !q_full;
  assign byte_acc        = s_axis_tvalid_i && !q_full;

  isfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_acc),
    .byte_i       (s_axis_tdata_i),
    .frame_o      (front_frame),
    .push_o       (front_push)
  );

  isfd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_frame),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .rdata_o (q_frame)
  );

  isfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (!q_empty),
    .frame_i     (q_frame),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

/* hdl/isfd_front.sv */
// header hunt, frame collection and checksum check
`default_nettype none

module isfd_front
  import isfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] byte_i,
  output frame_t          frame_o,
  output logic            push_o
);

  logic       inside_q, inside_d;
  logic [3:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] store_q [BodyLen];
  logic       wr_en;

  always_comb begin
    inside_d = inside_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    wr_en    = 1'b0;
    push_o   = 1'b0;
    if (byte_valid_i) begin
      if (!inside_q) begin
        if (byte_i == HdrByte) begin
          inside_d = 1'b1;
          pos_d    = 4'd1;
          sum_d    = byte_i;
          wr_en    = 1'b1;
        end
      end else if (pos_q < ChkPos) begin
        wr_en = 1'b1;
        pos_d = pos_q + 4'd1;
        sum_d = sum_q + byte_i;
      end else begin
        inside_d = 1'b0;
        pos_d    = 4'd0;
        sum_d    = 8'd0;
        push_o   = (sum_q == byte_i);
      end
    end
  end

  always_comb begin
    frame_o.type_byte = store_q[1];
    frame_o.kind      = kind_of(store_q[1]);
    for (int k = 0; k < NumWords; k++) begin
      frame_o.words[k] = {store_q[3+2*k], store_q[2+2*k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      pos_q    <= 4'd0;
      sum_q    <= 8'd0;
    end else begin
      inside_q <= inside_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[pos_q] <= byte_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/isfd_fifo.sv */
// short frame queue between collector and scaling pipeline
`default_nettype none

module isfd_fifo
  import isfd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  frame_t      wdata_i,
  output logic        full_o,
  output logic        empty_o,
  input  wire logic   pop_i,
  output frame_t      rdata_o
);

  frame_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (QPtrW+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/isfd_back.sv */
// scaling pipeline: multiply, offset, rounded constant divide, output register
`default_nettype none

module isfd_back
  import isfd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            avail_i,
  input  frame_t               frame_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [OutW-1:0]      out_data_o,
  output logic [1:0]           out_user_o
);

  logic en;
  logic va_q, vb_q, vc_q, vd_q, vo_q;
  frame_t fa_q, fb_q, fc_q, fd_q, fo_q;

  logic signed [31:0] p_q   [NumWords];
  lane_cfg_t          ca_q  [NumWords];
  logic [MagW-1:0]    m_b_q [NumWords];
  logic               neg_b_q [NumWords];
  den_e               den_b_q [NumWords];
  logic [MagW-1:0]    m_c_q [NumWords];
  logic [MagW-1:0]    qe_c_q [NumWords];
  logic               neg_c_q [NumWords];
  den_e               den_c_q [NumWords];
  logic [MagW-1:0]    q_d_q [NumWords];
  logic               neg_d_q [NumWords];
  logic [ScaledW-1:0] sc_q [NumWords];

  assign en          = !vo_q || out_ready_i;
  assign pop_o       = en && avail_i;
  assign out_valid_o = vo_q;
  assign out_user_o  = fo_q.kind;
  assign out_data_o  = {sc_q[3], sc_q[2], sc_q[1], sc_q[0], fo_q.words, fo_q.type_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      va_q <= avail_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      vo_q <= vd_q;
    end
  end

  for (genvar k = 0; k < NumWords; k++) begin : g_lane
    lane_cfg_t          cfg;
    logic signed [16:0] opnd;
    logic signed [32:0] prod;
    logic signed [31:0] sum;
    logic [31:0]        mag;
    logic [62:0]        rprod;
    logic [37:0]        qd;
    logic [37:0]        rem;
    logic [MagW-1:0]    qfix;
    logic [MagW-1:0]    qsgn;

    always_comb begin
      cfg  = lane_cfg(frame_i.kind, (k == NumWords - 1));
      opnd = cfg.zext ? {1'b0, frame_i.words[k]}
                      : {frame_i.words[k][15], frame_i.words[k]};
      prod = opnd * $signed({2'b00, cfg.mult});
      sum  = p_q[k] + (ca_q[k].add_ofs ? TempOfs : 32'sd0);
      mag  = sum[31] ? 32'(-sum) : 32'(sum);
      rprod = 63'(m_b_q[k]) * 63'(den_recip(den_b_q[k]));
      qd   = 38'(qe_c_q[k]) * 38'(den_value(den_c_q[k]));
      rem  = 38'(m_c_q[k]) - qd;
      if (den_c_q[k] == DEN_1) begin
        qfix = m_c_q[k];
      end else if (rem >= 38'(den_value(den_c_q[k]))) begin
        qfix = qe_c_q[k] + 1'b1;
      end else begin
        qfix = qe_c_q[k];
      end
      qsgn = neg_d_q[k] ? (~q_d_q[k] + 1'b1) : q_d_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q[k]     <= prod[31:0];
        ca_q[k]    <= cfg;
        m_b_q[k]   <= mag[MagW-1:0] + MagW'(den_half(ca_q[k].den));
        neg_b_q[k] <= sum[31];
        den_b_q[k] <= ca_q[k].den;
        m_c_q[k]   <= m_b_q[k];
        qe_c_q[k]  <= rprod[62:32];
        neg_c_q[k] <= neg_b_q[k];
        den_c_q[k] <= den_b_q[k];
        q_d_q[k]   <= qfix;
        neg_d_q[k] <= neg_c_q[k];
        sc_q[k]    <= qsgn[ScaledW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fa_q <= frame_i;
      fb_q <= fa_q;
      fc_q <= fb_q;
      fd_q <= fc_q;
      fo_q <= fd_q;
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// self-checking testbench for the imu serial frame decoder with a frame scoreboard
`default_nettype none

module tb_top;
  import isfd_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int HoldCycles = 400;
  localparam int ByteTarget = 1450;
  localparam int MaxLines = 40;
  localparam int ScaledLsb = 72;

  typedef struct packed {
    kind_e                     kind;
    logic [7:0]                type_byte;
    logic [NumWords-1:0][15:0] words;
    logic [NumWords-1:0][27:0] scaled;
  } decoded_frame_t;

  class frame_checker;
    bit             collecting;
    logic [3:0]     pos;
    logic [7:0]     sum;
    logic [7:0]     body [BodyLen];
    decoded_frame_t expected_frames [$];
    int             errors;

    function new();
      collecting = 1'b0;
      pos        = '0;
      sum        = '0;
      errors     = 0;
      foreach (body[i]) body[i] = '0;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    // round to nearest, ties away from zero
    function longint div_nearest(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    function void take_byte(logic [7:0] b);
      decoded_frame_t f;
      longint         w [NumWords];
      bit             good;
      if (!collecting) begin
        if (b == HdrByte) begin
          collecting = 1'b1;
          body[0]    = b;
          sum        = b;
          pos        = 4'd1;
        end
        return;
      end
      if (pos < ChkPos) begin
        body[pos] = b;
        sum       = sum + b;
        pos       = pos + 4'd1;
        return;
      end
      collecting = 1'b0;
      pos        = '0;
      good       = (sum == b);
      sum        = '0;
      if (!good) return;

      f = '0;
      f.type_byte = body[1];
      for (int k = 0; k < NumWords; k++) begin
        w[k] = longint'($signed({body[3+2*k], body[2+2*k]}));
        f.words[k] = w[k][15:0];
      end
      case (body[1])
        TypeAccel: begin
          f.kind = KIND_ACCEL;
          // 16 g * 9.8 in q16, temperature 192.76 scale plus 36.53 offset
          for (int k = 0; k < 3; k++) f.scaled[k] = 28'(div_nearest(w[k] * 1568, 5));
          f.scaled[3] = 28'(div_nearest(w[3] * 19276 + 239403008, 100));
        end
        TypeRate: begin
          f.kind = KIND_RATE;
          for (int k = 0; k < 3; k++) f.scaled[k] = 28'(w[k] * 4000);
          f.scaled[3] = 28'(div_nearest(w[3] * 16384, 25));
        end
        TypeAngle: begin
          f.kind = KIND_ANGLE;
          for (int k = 0; k < 3; k++) f.scaled[k] = 28'(w[k] * 360);
          f.scaled[3] = 28'(w[3] & 16'hFFFF);
        end
        default: f.kind = KIND_OTHER;
      endcase
      expected_frames.push_back(f);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxLines) $display("error: %s", msg);
    endtask

    task compare_field(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_frame(logic [1:0] u, logic [OutW-1:0] d);
      decoded_frame_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("item with no frame expected: %h %h", u, d));
        return;
      end
      want = expected_frames.pop_front();
      compare_field("frame_kind", u, want.kind);
      compare_field("type_byte", d[7:0], want.type_byte);
      for (int k = 0; k < NumWords; k++) begin
        compare_field($sformatf("raw_word_%0d", k), d[8+16*k +: 16], want.words[k]);
        compare_field($sformatf("scaled_%0d", k), d[ScaledLsb+ScaledW*k +: ScaledW],
                      want.scaled[k]);
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [7:0]        s_axis_tdata_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [OutW-1:0]   m_axis_tdata_o;
  logic [1:0]        m_axis_tuser_o;

  frame_checker sb = new();

  int burst_left;
  int frame_bytes;
  int idle_cycles;
  int rx_cycle;
  int hold_left;
  bit hold_req;

  imu_serial_frame_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    burst_left      = 0;
    frame_bytes     = 0;
    idle_cycles     = 0;
    rx_cycle        = 0;
    hold_left       = 0;
    hold_req        = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("imu_serial_frame_decoder: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: check, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_frame(m_axis_tuser_o, m_axis_tdata_o);
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= ($urandom_range(0, 1) == 0);
        2: m_axis_tready_i <= ($urandom_range(0, 4) == 0);
        default: m_axis_tready_i <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.take_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] type_byte, input logic [15:0] w0,
                            input logic [15:0] w1, input logic [15:0] w2,
                            input logic [15:0] w3, input bit corrupt);
    logic [7:0] bytes [BodyLen];
    logic [7:0] chk;
    bytes = '{HdrByte, type_byte, w0[7:0], w0[15:8], w1[7:0], w1[15:8],
              w2[7:0], w2[15:8], w3[7:0], w3[15:8]};
    chk = '0;
    foreach (bytes[i]) begin
      chk = chk + bytes[i];
      send_byte(bytes[i]);
    end
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(chk);
    frame_bytes += BodyLen + 1;
  endtask

  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 9))
      0, 1, 2: return TypeAccel;
      3, 4, 5: return TypeRate;
      6, 7, 8: return TypeAngle;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int choice;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every kind, unknown types, bad sum, idle noise
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h54);
    send_frame(TypeAccel, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 1'b0);
    send_frame(TypeAccel, 16'hFFFF, 16'hFFFD, 16'h0001, 16'h7FFF, 1'b0);
    send_frame(TypeRate, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 1'b0);
    send_frame(TypeRate, 16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF, 1'b0);
    send_frame(TypeAngle, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 1'b0);
    send_frame(TypeAngle, 16'hFFFF, 16'h0001, 16'h1234, 16'hFFFF, 1'b0);
    send_frame(8'h00, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0);
    send_frame(8'hFF, 16'h5555, 16'h55AA, 16'hAA55, 16'hFFFF, 1'b0);
    send_frame(HdrByte, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 1'b0);
    send_frame(TypeAccel, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b1);
    send_byte(8'hAA);
    send_frame(TypeRate, 16'hFFFE, 16'h0002, 16'hFFFC, 16'hFFFF, 1'b0);

    // random: mostly valid frames, some bad sums, some loose bytes
    while (frame_bytes < ByteTarget) begin
      if (frame_bytes > 300 && frame_bytes < 320) hold_req = 1'b1;
      choice = $urandom_range(0, 19);
      if (choice < 16) begin
        send_frame(pick_type(), pick_word(), pick_word(), pick_word(), pick_word(), 1'b0);
      end else if (choice < 18) begin
        send_frame(pick_type(), pick_word(), pick_word(), pick_word(), pick_word(), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d frames never came out", sb.pending()));
    if (sb.errors == 0) begin
      $display("imu_serial_frame_decoder: match");
    end else begin
      $display("imu_serial_frame_decoder: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* imu_serial_frame_decoder.f */
hdl/isfd_pkg.sv
hdl/isfd_front.sv
hdl/isfd_fifo.sv
hdl/isfd_back.sv
hdl/imu_serial_frame_decoder.sv
test/tb_top.sv
